FILE: hw/rtl/hbpwm_pkg.sv
// Shared constants, types and register codes for the H-bridge PWM driver.
package hbpwm_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int DIV_CNT_WIDTH = $clog2(COUNT_WIDTH);
	localparam int CFG_IDX_WIDTH = 2;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// configuration register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] REG_PERIOD     = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_FULL_SPEED = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_DEAD_TICKS = 2'd2;

	// item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	// direction-change phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_WAIT = 2'd1;
	localparam logic [1:0] PH_DEAD = 2'd2;

	localparam count_t PERIOD_RST     = count_t'(20000);
	localparam count_t FULL_SPEED_RST = count_t'(225);
	localparam count_t DEAD_TICKS_RST = count_t'(1000);
	localparam count_t COMPARE_RST    = count_t'(5000);

	typedef struct packed {
		logic capture;
		logic mul;
		logic div_step;
		logic exec;
	} hbpwm_cmd_t;

	typedef struct packed {
		logic phase_idle;
	} hbpwm_status_t;

endpackage

FILE: hw/rtl/hbpwm_ifs.sv
// Channel interfaces: command/tick items, results and configuration writes.
interface hbpwm_item_if;
	import hbpwm_pkg::*;
	logic   valid;
	logic   ready;
	logic   kind;
	logic   direction;
	count_t speed;
	modport source (output valid, kind, direction, speed, input ready);
	modport sink (input valid, kind, direction, speed, output ready);
endinterface

interface hbpwm_result_if;
	logic valid;
	logic ready;
	logic in1_level;
	logic in2_level;
	logic switching;
	logic refused;
	modport source (output valid, in1_level, in2_level, switching, refused, input ready);
	modport sink (input valid, in1_level, in2_level, switching, refused, output ready);
endinterface

interface hbpwm_cfg_if;
	import hbpwm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_WIDTH-1:0] index;
	count_t                   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/hbpwm_ctrl.sv
// Controller: capture, duty multiply/divide (accepted commands only), state update.
module hbpwm_ctrl import hbpwm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          item_kind,
	output logic          item_ready,
	input  logic          result_ready,
	output logic          result_valid,
	input  hbpwm_status_t status,
	output hbpwm_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_EXEC = 2'd3;

	localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(COUNT_WIDTH - 1);

	logic [1:0]               state_q, state_d;
	logic [DIV_CNT_WIDTH-1:0] div_cnt_q;
	logic                     valid_q;
	logic                     accept;
	logic                     out_free;

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign out_free     = !valid_q || result_ready;
	assign result_valid = valid_q;

	always_comb begin
		cmd.capture  = accept;
		cmd.mul      = (state_q == S_MUL);
		cmd.div_step = (state_q == S_DIV);
		cmd.exec     = (state_q == S_EXEC) && out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					// only an accepted command needs the duty division
					state_d = (item_kind == KIND_CMD && status.phase_idle) ? S_MUL : S_EXEC;
				end
			end
			S_MUL:  state_d = S_DIV;
			S_DIV: begin
				if (div_cnt_q == DIV_LAST) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) div_cnt_q <= div_cnt_q + 1'b1;
			else div_cnt_q <= '0;
			if (cmd.exec) valid_q <= 1'b1;
			else if (result_ready) valid_q <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/hbpwm_dp.sv
// Datapath: config registers, PWM channels, direction-change state and duty divider.
module hbpwm_dp import hbpwm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  count_t                   cfg_data,
	input  logic                     item_kind,
	input  logic                     item_direction,
	input  count_t                   item_speed,
	input  hbpwm_cmd_t               cmd,
	output hbpwm_status_t            status,
	output logic                     in1_level,
	output logic                     in2_level,
	output logic                     switching,
	output logic                     refused
);

	count_t     period_q, full_speed_q, dead_ticks_q;
	logic       kind_q, dir_q;
	count_t     speed_q;
	count_t     rem_q, low_q, quo_q;
	count_t     cnt1_q, cnt2_q, cmp1_q, cmp2_q;
	logic       run1_q, run2_q;
	logic [1:0] phase_q;
	count_t     dead_left_q;
	logic       pdir_q;
	count_t     pduty_q;

	logic [2*COUNT_WIDTH-1:0] prod;
	logic [COUNT_WIDTH:0]     trial;
	logic                     trial_ge;
	count_t                   rem_nxt;

	logic [1:0] ph, phase_n;
	logic       tick, cmd_ok, is_refused;
	count_t     cnt1_n, cnt2_n, cmp1_n, cmp2_n;
	count_t     duty, pduty_n, dead_left_n, dl_dec;
	logic       pdir_n, run1_n, run2_n;
	logic       opp_run, do_check, done, dead_dec, start;
	count_t     opp_cnt, opp_cmp;

	function automatic count_t advance(input count_t c, input count_t top);
		advance = (c >= top) ? '0 : c + 1'b1;
	endfunction

	// 16 x 16 product, registered into the divider's remainder and shift word
	assign prod = {{COUNT_WIDTH{1'b0}}, speed_q} * {{COUNT_WIDTH{1'b0}}, period_q};

	// restoring division, one quotient bit per step; quotient fits when speed < full_speed
	assign trial    = {rem_q, low_q[COUNT_WIDTH-1]};
	assign trial_ge = (trial >= {1'b0, full_speed_q});
	always_comb begin
		if (trial_ge) rem_nxt = COUNT_WIDTH'(trial - {1'b0, full_speed_q});
		else rem_nxt = trial[COUNT_WIDTH-1:0];
	end

	assign ph = (phase_q == PH_WAIT || phase_q == PH_DEAD) ? phase_q : PH_IDLE;
	assign status.phase_idle = (ph == PH_IDLE);

	always_comb begin
		tick       = (kind_q == KIND_TICK);
		cmd_ok     = (kind_q == KIND_CMD) && (ph == PH_IDLE);
		is_refused = (kind_q == KIND_CMD) && (ph != PH_IDLE);

		cnt1_n = (tick && run1_q) ? advance(cnt1_q, period_q) : cnt1_q;
		cnt2_n = (tick && run2_q) ? advance(cnt2_q, period_q) : cnt2_q;

		if (full_speed_q == '0) duty = (speed_q != '0) ? period_q : '0;
		else if (speed_q >= full_speed_q) duty = period_q;
		else duty = quo_q;

		pdir_n  = cmd_ok ? dir_q : pdir_q;
		pduty_n = cmd_ok ? duty : pduty_q;

		// opposite channel's pulse is over once stopped, full-on or past compare
		do_check = (tick && ph == PH_WAIT) || cmd_ok;
		opp_run  = pdir_n ? run1_q : run2_q;
		opp_cnt  = pdir_n ? cnt1_n : cnt2_n;
		opp_cmp  = pdir_n ? cmp1_q : cmp2_q;
		done     = do_check && (!opp_run || opp_cmp >= period_q || opp_cnt > opp_cmp);

		dead_dec = tick && (ph == PH_DEAD);
		dl_dec   = dead_left_q - 1'b1;
		start    = (done && dead_ticks_q == '0) || (dead_dec && dl_dec == '0);

		run1_n = run1_q;
		run2_n = run2_q;
		if (done && pdir_n) run1_n = 1'b0;
		if (done && !pdir_n) run2_n = 1'b0;
		if (start && !pdir_n) run1_n = 1'b1;
		if (start && pdir_n) run2_n = 1'b1;
		cmp1_n = (start && !pdir_n) ? pduty_n : cmp1_q;
		cmp2_n = (start && pdir_n) ? pduty_n : cmp2_q;

		phase_n = ph;
		if (cmd_ok) phase_n = PH_WAIT;
		if (done) phase_n = PH_DEAD;
		if (start) phase_n = PH_IDLE;

		dead_left_n = dead_left_q;
		if (dead_dec) dead_left_n = dl_dec;
		if (done) dead_left_n = dead_ticks_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= PERIOD_RST;
			full_speed_q <= FULL_SPEED_RST;
			dead_ticks_q <= DEAD_TICKS_RST;
			cnt1_q       <= '0;
			cnt2_q       <= '0;
			cmp1_q       <= COMPARE_RST;
			cmp2_q       <= COMPARE_RST;
			run1_q       <= 1'b1;
			run2_q       <= 1'b0;
			phase_q      <= PH_IDLE;
			dead_left_q  <= '0;
			pdir_q       <= 1'b0;
			pduty_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PERIOD:     period_q     <= cfg_data;
					REG_FULL_SPEED: full_speed_q <= cfg_data;
					REG_DEAD_TICKS: dead_ticks_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.exec) begin
				cnt1_q      <= cnt1_n;
				cnt2_q      <= cnt2_n;
				cmp1_q      <= cmp1_n;
				cmp2_q      <= cmp2_n;
				run1_q      <= run1_n;
				run2_q      <= run2_n;
				phase_q     <= phase_n;
				dead_left_q <= dead_left_n;
				pdir_q      <= pdir_n;
				pduty_q     <= pduty_n;
			end
		end
	end

	// payload, divider and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= item_kind;
			dir_q   <= item_direction;
			speed_q <= item_speed;
		end
		if (cmd.mul) begin
			rem_q <= prod[2*COUNT_WIDTH-1:COUNT_WIDTH];
			low_q <= prod[COUNT_WIDTH-1:0];
		end
		if (cmd.div_step) begin
			rem_q <= rem_nxt;
			low_q <= {low_q[COUNT_WIDTH-2:0], 1'b0};
			quo_q <= {quo_q[COUNT_WIDTH-2:0], trial_ge};
		end
		if (cmd.exec) begin
			in1_level <= run1_n && (cnt1_n < cmp1_n);
			in2_level <= run2_n && (cnt2_n < cmp2_n);
			switching <= (phase_n != PH_IDLE);
			refused   <= is_refused;
		end
	end

endmodule

FILE: hw/rtl/hbridge_pwm_direction_switch_top.sv
// Top level: H-bridge PWM driver with dead-time direction change.
// A tick or a refused command goes straight from acceptance to the state update;
//   an accepted command first runs the multiply and the 16-step restoring divide.
// One transaction at a time: a new item is taken once the last result is loaded, and
//   the update waits while an earlier result is still unread.
// Reset (arst_n low): config to defaults, channel one running, no result pending.
module hbridge_pwm_direction_switch_top import hbpwm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	hbpwm_item_if.sink       item,
	hbpwm_result_if.source   result,
	hbpwm_cfg_if.sink        cfg
);

	hbpwm_cmd_t    cmd;
	hbpwm_status_t status;

	assign cfg.ready = 1'b1;

	hbpwm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_kind    (item.kind),
		.item_ready   (item.ready),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.status       (status),
		.cmd          (cmd)
	);

	hbpwm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg.valid && cfg.ready),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.item_kind      (item.kind),
		.item_direction (item.direction),
		.item_speed     (item.speed),
		.cmd            (cmd),
		.status         (status),
		.in1_level      (result.in1_level),
		.in2_level      (result.in2_level),
		.switching      (result.switching),
		.refused        (result.refused)
	);

	// at most one channel runs, so both bridge inputs are never high together
	a_no_shoot_through: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.in1_level && result.in2_level))
		else $error("both bridge inputs high");

	// a command is refused only while a change is in progress, which it leaves untouched
	a_refused_switching: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.refused |-> result.switching)
		else $error("refused transaction outside a direction change");

	// one transaction in flight: input closes right after an acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("input accepted while a transaction is in flight");

	// the state update and the divider never run in the same cycle
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mul, cmd.div_step, cmd.exec}))
		else $error("controller issued overlapping commands");

endmodule
